[rtl/gbn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, word types and control structs for the Go-Back-N sender
// window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_COUNT = 20;
  localparam int WINDOW    = 10;
  localparam int SEQ_W     = $clog2(SEQ_COUNT);

  localparam logic [15:0] TOTAL_RESET = 16'd0;
  localparam logic [7:0]  LIMIT_RESET = 8'd20;

  // configuration register indexes
  localparam logic [7:0] CFG_TOTAL_PACKETS = 8'd0;
  localparam logic [7:0] CFG_TIMEOUT_LIMIT = 8'd1;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef struct packed {
    logic       start_req;
    logic       ack_present;
    logic [7:0] ack_code;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_seq;
    logic [15:0] send_packet_index;
    logic        timeout_fired;
    logic [7:0]  rewind_count;
    logic [7:0]  base_seq;
    logic        transfer_done;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;        // latch the input word
    logic do_send;        // send phase of a poll
    logic do_ack;         // ack / miss phase of a poll
    logic load_out;       // load the output register
    logic out_from_hold;  // take the held result instead of the fresh one
  } gbn_cmd_t;

  // forward distance from one sequence number to another, modulo SEQ_COUNT
  function automatic seq_t gbn_dist(input seq_t from, input seq_t to);
    logic [SEQ_W:0] t;
    t = {1'b0, to} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, from};
    if (t >= (SEQ_W+1)'(SEQ_COUNT)) begin
      t = t - (SEQ_W+1)'(SEQ_COUNT);
    end
    return t[SEQ_W-1:0];
  endfunction

  function automatic seq_t gbn_inc(input seq_t s);
    return (s == seq_t'(SEQ_COUNT - 1)) ? '0 : s + seq_t'(1);
  endfunction

endpackage

[rtl/gbn_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_ctrl
// Poll sequencer: accept, send phase, ack phase, then hand the result word
// to the output register (holding it back while the output is still full).
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  output gbn_pkg::gbn_cmd_t cmd
);
  import gbn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_ACK,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_SEND;
      end
      ST_SEND: begin
        cmd.do_send = 1'b1;
        state_nxt   = ST_ACK;
      end
      ST_ACK: begin
        cmd.do_ack   = 1'b1;
        cmd.load_out = out_free;
        state_nxt    = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        cmd.out_from_hold = 1'b1;
        cmd.load_out      = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/gbn_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_datapath
// Window state (slot flags, next/base sequence, counters), configuration
// registers, input latch and output register.
// ----------------------------------------------------------------------------
module gbn_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  gbn_pkg::gbn_cmd_t  cmd,
  input  gbn_pkg::in_word_t  in_data,
  input  logic               cfg_wr,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output gbn_pkg::out_word_t out_data
);
  import gbn_pkg::*;

  logic [15:0]          total_r;
  logic [7:0]           limit_r;
  in_word_t             in_r;

  logic [SEQ_COUNT-1:0] slot_free_r, slot_nxt;
  seq_t                 next_r, next_nxt;
  seq_t                 base_r, base_nxt;
  logic [15:0]          sent_r, sent_nxt;
  logic [7:0]           miss_r, miss_nxt;
  logic                 done_r, done_nxt;

  // send-phase result, kept for the ack phase
  logic                 sv_r;
  seq_t                 sseq_r;
  logic [15:0]          sidx_r;

  out_word_t            res_comb, res_r, out_r;

  // send phase
  seq_t   outst_now;
  logic   send_ok;

  assign outst_now = gbn_dist(base_r, next_r);
  assign send_ok   = !in_r.start_req && !done_r && (outst_now < seq_t'(WINDOW)) &&
                     slot_free_r[next_r] && (sent_r < total_r);

  // ack / miss phase
  logic       ack_ok;
  seq_t       idx, span;
  logic [8:0] miss_inc;
  logic       tf;
  logic [7:0] rcount;

  always_comb begin
    ack_ok   = in_r.ack_present && (in_r.ack_code != 8'd0) &&
               (in_r.ack_code <= 8'(SEQ_COUNT));
    idx      = seq_t'(in_r.ack_code - 8'd1);
    span     = gbn_dist(base_r, idx);
    miss_inc = {1'b0, miss_r} + 9'd1;

    slot_nxt = slot_free_r;
    next_nxt = next_r;
    base_nxt = base_r;
    sent_nxt = sent_r;
    miss_nxt = miss_r;
    tf       = 1'b0;
    rcount   = 8'd0;

    if (!in_r.start_req && !done_r) begin
      if (ack_ok) begin
        if (span < outst_now) begin
          for (int j = 0; j < SEQ_COUNT; j++) begin
            if (gbn_dist(base_r, seq_t'(j)) <= span) slot_nxt[j] = 1'b1;
          end
          base_nxt = gbn_inc(idx);
        end
        miss_nxt = 8'd0;
      end else if (miss_inc > {1'b0, limit_r}) begin
        // go back to the window base
        miss_nxt = 8'd0;
        tf       = 1'b1;
        rcount   = 8'(outst_now);
        for (int j = 0; j < SEQ_COUNT; j++) begin
          if (gbn_dist(base_r, seq_t'(j)) < seq_t'(WINDOW)) slot_nxt[j] = 1'b1;
        end
        sent_nxt = (sent_r >= 16'(outst_now)) ? sent_r - 16'(outst_now) : 16'd0;
        next_nxt = base_r;
      end else begin
        miss_nxt = miss_inc[7:0];
      end
    end

    done_nxt = done_r;
    if (!done_r && (sent_nxt >= total_r) && (&slot_nxt)) done_nxt = 1'b1;

    res_comb.send_valid        = sv_r;
    res_comb.send_seq          = 8'(sseq_r);
    res_comb.send_packet_index = sidx_r;
    res_comb.timeout_fired     = tf;
    res_comb.rewind_count      = rcount;
    res_comb.base_seq          = 8'(base_nxt);
    res_comb.transfer_done     = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= TOTAL_RESET;
      limit_r     <= LIMIT_RESET;
      slot_free_r <= '1;
      next_r      <= '0;
      base_r      <= '0;
      sent_r      <= 16'd0;
      miss_r      <= 8'd0;
      done_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_TOTAL_PACKETS: total_r <= cfg_data;
          CFG_TIMEOUT_LIMIT: limit_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.do_send) begin
        if (in_r.start_req) begin
          slot_free_r <= '1;
          next_r      <= '0;
          base_r      <= '0;
          sent_r      <= 16'd0;
          miss_r      <= 8'd0;
          done_r      <= 1'b0;
        end else if (send_ok) begin
          slot_free_r[next_r] <= 1'b0;
          next_r              <= gbn_inc(next_r);
          sent_r              <= sent_r + 16'd1;
        end
      end
      if (cmd.do_ack) begin
        slot_free_r <= slot_nxt;
        next_r      <= next_nxt;
        base_r      <= base_nxt;
        sent_r      <= sent_nxt;
        miss_r      <= miss_nxt;
        done_r      <= done_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.do_send) begin
      sv_r   <= send_ok;
      sseq_r <= send_ok ? next_r : '0;
      sidx_r <= send_ok ? sent_r : 16'd0;
    end
    if (cmd.do_ack) res_r <= res_comb;
    if (cmd.load_out) out_r <= cmd.out_from_hold ? res_r : res_comb;
  end

  assign out_data = out_r;

endmodule

[rtl/go_back_n_sender_window_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Go-Back-N sender window: one poll in, one result word out.
// ----------------------------------------------------------------------------
// Result path: poll accept, send phase, ack phase, then the output register.
// A new poll is accepted only once the previous one is back in idle;
//   the window registers are updated twice per poll, first by the send and
//   then by the ack or miss. A stalled output holds the next result in ST_HOLD.
// A pending result waits in the output register while the next poll starts.
// Reset (rst_n low, synchronous): window cleared, total_packets 0, limit 20.
module go_back_n_sender_window_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gbn_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gbn_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gbn_pkg::*;

  gbn_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  gbn_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

[rtl/gbn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks for the sender window, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input gbn_pkg::out_word_t out_data
);
  import gbn_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // a poll occupies the block for at least its two phases
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("poll accepted on consecutive cycles");

  // never more rewound than a window holds
  a_rewind_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rewind_count <= 8'(WINDOW))
    else $error("rewind count beyond window");

  // sequence numbers stay inside the sequence space
  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.base_seq < 8'(SEQ_COUNT)) &&
                  (out_data.send_seq < 8'(SEQ_COUNT)))
    else $error("sequence number out of range");

endmodule

bind go_back_n_sender_window_top gbn_checker u_gbn_checker (.*);
